/* rtl/ipv4rx_pkg.sv */
// package for the ipv4 receive header checker: codes, word positions, defaults
`default_nettype none

package ipv4rx_pkg;

    localparam int MAX_HANDLERS_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_ADDR  = 2'd0,
        CFG_NET_MASK    = 2'd1,
        CFG_PROTO_TABLE = 2'd2,
        CFG_PROTO_COUNT = 2'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        V_ACCEPT     = 4'd0,
        V_SHORT      = 4'd1,
        V_VERSION    = 4'd2,
        V_IHL        = 4'd3,
        V_SHORT_HDR  = 4'd4,
        V_CHECKSUM   = 4'd5,
        V_LENGTH     = 4'd6,
        V_FRAGMENT   = 4'd7,
        V_NOT_OURS   = 4'd8,
        V_NO_HANDLER = 4'd9
    } t_verdict;

    // header word positions after the first word
    localparam logic [4:0] W_TOTAL_LEN = 5'd1;
    localparam logic [4:0] W_FRAG      = 5'd3;
    localparam logic [4:0] W_PROTO     = 5'd4;
    localparam logic [4:0] W_CHECKSUM  = 5'd5;
    localparam logic [4:0] W_SRC_HI    = 5'd6;
    localparam logic [4:0] W_SRC_LO    = 5'd7;
    localparam logic [4:0] W_DST_HI    = 5'd8;
    localparam logic [4:0] W_DST_LO    = 5'd9;

    localparam logic [3:0]  HDR_VERSION  = 4'd4;
    localparam logic [3:0]  MIN_IHL      = 4'd5;
    localparam logic [15:0] MIN_BUF_LEN  = 16'd20;
    localparam logic [7:0]  LOOPBACK_NET = 8'd127;

endpackage

`default_nettype wire

/* rtl/ipv4_rx_header_checker.sv */
// ipv4 receive header checker: one word per cycle unless a stalled result holds the input, one verdict per packet
// the word that decides a verdict passes the input register, then the verdict loads into the result register
// throughput: one header or payload word per cycle while the output is not stalled, no bubbles between packets
// the decision on the last header word is one folded add plus compares into the result register
// reset (synchronous, active low) clears the configuration registers, the header walk flag
// and both valid flags; the other parse registers load on every first word
`default_nettype none

module ipv4_rx_header_checker #(
    parameter int MAX_HANDLERS = ipv4rx_pkg::MAX_HANDLERS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [15:0]                       i_header_word,
    input  wire logic                              i_first,
    input  wire logic [15:0]                       i_buffer_len,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [3:0]                             o_verdict,
    output logic [5:0]                             o_header_bytes,
    output logic [15:0]                            o_tot_length,
    output logic [15:0]                            o_payload_length,
    output logic                                   o_trimmed,
    output logic [7:0]                             o_proto_number,
    output logic [2:0]                             o_handler_index,
    output logic [31:0]                            o_source_addr,
    output logic [31:0]                            o_dst_addr,

    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ipv4rx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ipv4rx_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TABLE_W = MAX_HANDLERS * 8;

    // configuration
    logic [31:0]        r_local_addr;
    logic [31:0]        r_net_mask;
    logic [TABLE_W-1:0] r_proto_table;
    logic [3:0]         r_proto_count;

    // input register
    logic        r_in_valid;
    logic [15:0] r_word;
    logic        r_first;
    logic [15:0] r_blen;

    // parse state
    logic        r_in_header, n_in_header;
    logic [4:0]  r_word_index, n_word_index;
    logic [3:0]  r_ihl_words, n_ihl_words;
    logic [15:0] r_held_blen, n_held_blen;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_stored_csum, n_stored_csum;
    logic [15:0] r_total_len, n_total_len;
    logic [15:0] r_frag_word, n_frag_word;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;

    // result register
    logic                 r_out_valid;
    ipv4rx_pkg::t_verdict r_verdict, n_verdict;
    logic [5:0]           r_hdr_bytes, n_hdr_bytes;
    logic [15:0]          r_res_total, n_res_total;
    logic [15:0]          r_res_payload, n_res_payload;
    logic                 r_res_trimmed, n_res_trimmed;
    logic [7:0]           r_res_proto, n_res_proto;
    logic [2:0]           r_res_hidx, n_res_hidx;
    logic [31:0]          r_res_src, n_res_src;
    logic [31:0]          r_res_dst, n_res_dst;

    logic        has_result;
    logic        advance;
    logic [16:0] sum_wide;
    logic [15:0] sum_folded;
    logic [5:0]  idx_next;
    logic [5:0]  last_bound;
    logic [5:0]  hb_late;
    logic [3:0]  first_ihl;
    logic [5:0]  hb_first;
    logic        addr_ok;
    logic        hit_any;
    logic [2:0]  hit_idx;

    assign o_cfg_ready = 1'b1;

    assign advance    = r_in_valid && (!has_result || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    assign sum_wide   = {1'b0, r_sum} + {1'b0, r_word};
    assign sum_folded = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
    assign idx_next   = {1'b0, r_word_index} + 6'd1;
    assign last_bound = {1'b0, r_ihl_words, 1'b0};
    assign hb_late    = {r_ihl_words, 2'b00};
    assign first_ihl  = r_word[11:8];
    assign hb_first   = {first_ihl, 2'b00};

    assign addr_ok = (n_dst == r_local_addr)
                  || (n_dst[31:24] == ipv4rx_pkg::LOOPBACK_NET)
                  || (n_dst == 32'hFFFF_FFFF)
                  || (n_dst == (r_local_addr | ~r_net_mask));

    // first matching protocol entry among the valid ones
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = MAX_HANDLERS - 1; i >= 0; i--) begin
            if ((4'(i) < r_proto_count) && (r_proto_table[i*8 +: 8] == n_proto)) begin
                hit_any = 1'b1;
                hit_idx = 3'(i);
            end
        end
    end

    always_comb begin
        n_in_header   = r_in_header;
        n_word_index  = r_word_index;
        n_ihl_words   = r_ihl_words;
        n_held_blen   = r_held_blen;
        n_sum         = r_sum;
        n_stored_csum = r_stored_csum;
        n_total_len   = r_total_len;
        n_frag_word   = r_frag_word;
        n_proto       = r_proto;
        n_src         = r_src;
        n_dst         = r_dst;
        has_result    = 1'b0;
        n_verdict     = ipv4rx_pkg::V_ACCEPT;
        n_hdr_bytes   = hb_late;
        n_res_total   = '0;
        n_res_payload = '0;
        n_res_trimmed = 1'b0;
        n_res_proto   = '0;
        n_res_hidx    = '0;
        n_res_src     = '0;
        n_res_dst     = '0;

        if (r_in_valid && r_first) begin
            n_ihl_words   = first_ihl;
            n_held_blen   = r_blen;
            n_total_len   = '0;
            n_frag_word   = '0;
            n_proto       = '0;
            n_src         = '0;
            n_dst         = '0;
            n_stored_csum = '0;
            n_sum         = r_word;
            n_word_index  = 5'd1;
            n_in_header   = 1'b0;
            n_hdr_bytes   = hb_first;
            has_result    = 1'b1;
            priority if (r_blen < ipv4rx_pkg::MIN_BUF_LEN) begin
                n_verdict = ipv4rx_pkg::V_SHORT;
            end else if (r_word[15:12] != ipv4rx_pkg::HDR_VERSION) begin
                n_verdict = ipv4rx_pkg::V_VERSION;
            end else if (first_ihl < ipv4rx_pkg::MIN_IHL) begin
                n_verdict = ipv4rx_pkg::V_IHL;
            end else if (r_blen < {10'd0, hb_first}) begin
                n_verdict = ipv4rx_pkg::V_SHORT_HDR;
            end else begin
                n_in_header = 1'b1;
                has_result  = 1'b0;
            end
        end else if (r_in_valid && r_in_header) begin
            if (r_word_index == ipv4rx_pkg::W_CHECKSUM) begin
                n_stored_csum = r_word;
            end else begin
                n_sum = sum_folded;
            end
            unique case (r_word_index)
                ipv4rx_pkg::W_TOTAL_LEN: n_total_len = r_word;
                ipv4rx_pkg::W_FRAG:      n_frag_word = r_word;
                ipv4rx_pkg::W_PROTO:     n_proto     = r_word[7:0];
                ipv4rx_pkg::W_SRC_HI:    n_src       = {r_word, r_src[15:0]};
                ipv4rx_pkg::W_SRC_LO:    n_src       = {r_src[31:16], r_word};
                ipv4rx_pkg::W_DST_HI:    n_dst       = {r_word, r_dst[15:0]};
                ipv4rx_pkg::W_DST_LO:    n_dst       = {r_dst[31:16], r_word};
                default: ;
            endcase
            n_word_index = idx_next[4:0];
            if (idx_next >= last_bound) begin
                n_in_header   = 1'b0;
                has_result    = 1'b1;
                n_res_total   = n_total_len;
                n_res_trimmed = (n_total_len < n_held_blen);
                n_res_proto   = n_proto;
                n_res_src     = n_src;
                n_res_dst     = n_dst;
                priority if (~n_sum != n_stored_csum) begin
                    n_verdict = ipv4rx_pkg::V_CHECKSUM;
                end else if ((n_total_len > n_held_blen)
                          || (n_total_len < {10'd0, hb_late})) begin
                    n_verdict = ipv4rx_pkg::V_LENGTH;
                end else if (n_frag_word[13:0] != 14'd0) begin
                    n_verdict = ipv4rx_pkg::V_FRAGMENT;
                end else if (!addr_ok) begin
                    n_verdict = ipv4rx_pkg::V_NOT_OURS;
                end else if (!hit_any) begin
                    n_verdict = ipv4rx_pkg::V_NO_HANDLER;
                end else begin
                    n_verdict     = ipv4rx_pkg::V_ACCEPT;
                    n_res_payload = n_total_len - {10'd0, hb_late};
                    n_res_hidx    = hit_idx;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr  <= '0;
            r_net_mask    <= '0;
            r_proto_table <= '0;
            r_proto_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (ipv4rx_pkg::t_cfg_index'(i_cfg_index))
                ipv4rx_pkg::CFG_LOCAL_ADDR:  r_local_addr  <= i_cfg_data[31:0];
                ipv4rx_pkg::CFG_NET_MASK:    r_net_mask    <= i_cfg_data[31:0];
                ipv4rx_pkg::CFG_PROTO_TABLE: r_proto_table <= i_cfg_data[TABLE_W-1:0];
                ipv4rx_pkg::CFG_PROTO_COUNT: r_proto_count <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_word  <= i_header_word;
            r_first <= i_first;
            r_blen  <= i_buffer_len;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header <= 1'b0;
        end else if (advance) begin
            r_in_header <= n_in_header;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_word_index  <= n_word_index;
            r_ihl_words   <= n_ihl_words;
            r_held_blen   <= n_held_blen;
            r_sum         <= n_sum;
            r_stored_csum <= n_stored_csum;
            r_total_len   <= n_total_len;
            r_frag_word   <= n_frag_word;
            r_proto       <= n_proto;
            r_src         <= n_src;
            r_dst         <= n_dst;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_verdict     <= n_verdict;
            r_hdr_bytes   <= n_hdr_bytes;
            r_res_total   <= n_res_total;
            r_res_payload <= n_res_payload;
            r_res_trimmed <= n_res_trimmed;
            r_res_proto   <= n_res_proto;
            r_res_hidx    <= n_res_hidx;
            r_res_src     <= n_res_src;
            r_res_dst     <= n_res_dst;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_verdict        = r_verdict;
    assign o_header_bytes   = r_hdr_bytes;
    assign o_tot_length     = r_res_total;
    assign o_payload_length = r_res_payload;
    assign o_trimmed        = r_res_trimmed;
    assign o_proto_number   = r_res_proto;
    assign o_handler_index  = r_res_hidx;
    assign o_source_addr    = r_res_src;
    assign o_dst_addr       = r_res_dst;

    a_header_ihl_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_header |-> (r_ihl_words >= ipv4rx_pkg::MIN_IHL))
        else $error("header walk running with ihl below minimum");

    a_index_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_header |-> ({1'b0, r_word_index} < last_bound))
        else $error("word index passed the last header word");

    a_accept_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_verdict == ipv4rx_pkg::V_ACCEPT))
        |-> ((r_res_payload + {10'd0, r_hdr_bytes}) == r_res_total))
        else $error("accepted payload length does not match total length");

    a_early_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_verdict == ipv4rx_pkg::V_SHORT)
                      || (r_verdict == ipv4rx_pkg::V_VERSION)
                      || (r_verdict == ipv4rx_pkg::V_IHL)
                      || (r_verdict == ipv4rx_pkg::V_SHORT_HDR)))
        |-> ((r_res_total == 16'd0) && (r_res_src == 32'd0) && (r_res_dst == 32'd0)))
        else $error("early verdict carries header fields");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && has_result && r_out_valid))
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire
